// ===== hdl/lnp_pkg.sv =====
// Shared types and constants for the link-packet receiver.
// No dependencies; imported by lnp_parse_core and lnp_packet_receiver.
`default_nettype none

package lnp_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 9;
    localparam int MAX_BURST = 511;

    // header byte is 11110ttt
    localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] HDR_MATCH = 8'hF0;
    localparam logic [BYTE_W-1:0] SUM_SEED  = 8'hFF;

    localparam logic [2:0] TYPE_INTEGRITY = 3'd0;
    localparam logic [2:0] TYPE_ADDRESSED = 3'd1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_DEST   = 3'd2,
        PH_SRC    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_INTEGRITY_OK = 3'd0,
        ST_ADDRESSED_OK = 3'd1,
        ST_UNKNOWN_OK   = 3'd2,
        ST_BAD_CHECKSUM = 3'd3,
        ST_SIZE_MISMATCH = 3'd4
    } t_status;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_done;
        t_status           frame_status;
        logic [2:0]        frame_type;
        logic [3:0]        dest_host;
        logic [3:0]        dest_port;
        logic [3:0]        src_host;
        logic [3:0]        src_port;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/lnp_parse_core.sv =====
// Packet parse state machine: phase, running sum, counters, captured addresses.
// Depends on lnp_pkg; produces the result word for the byte being accepted.
`default_nettype none

module lnp_parse_core
    import lnp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic [LEN_W-1:0]  i_burst_len,
    output t_result                o_result
);

    t_phase            r_phase, n_phase;
    logic [2:0]        r_type, n_type;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [LEN_W-1:0]  r_end, n_end;
    logic [BYTE_W-1:0] r_dest, n_dest;
    logic [BYTE_W-1:0] r_src, n_src;

    logic [LEN_W-1:0]  count_inc;
    logic [BYTE_W-1:0] sum_add;
    logic [LEN_W:0]    len_plus3;
    logic              size_bad;
    logic [LEN_W-1:0]  end_calc;

    logic              pv, done;
    t_status           status;

    assign count_inc = r_count + LEN_W'(1);
    assign sum_add   = r_sum + i_rx_byte;
    assign len_plus3 = (LEN_W+1)'(i_rx_byte) + (LEN_W+1)'(3);
    assign size_bad  = (len_plus3 != {1'b0, i_burst_len})
                    || ({1'b0, i_burst_len} > (LEN_W+1)'(MAX_BURST));
    assign end_calc  = LEN_W'(i_rx_byte) + LEN_W'(2);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_sum   = r_sum;
        n_count = r_count;
        n_end   = r_end;
        n_dest  = r_dest;
        n_src   = r_src;
        case (r_phase)
            PH_LENGTH: begin
                n_count = LEN_W'(2);
                if (size_bad) begin
                    n_phase = PH_HEADER;
                end else begin
                    n_sum = sum_add;
                    n_end = end_calc;
                    if (LEN_W'(2) >= end_calc)
                        n_phase = PH_CRC;
                    else if (r_type == TYPE_ADDRESSED)
                        n_phase = PH_DEST;
                    else
                        n_phase = PH_DATA;
                end
            end
            PH_DEST: begin
                n_sum   = sum_add;
                n_dest  = i_rx_byte;
                n_count = count_inc;
                n_phase = (count_inc >= r_end) ? PH_CRC : PH_SRC;
            end
            PH_SRC: begin
                n_sum   = sum_add;
                n_src   = i_rx_byte;
                n_count = count_inc;
                n_phase = (count_inc >= r_end) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                n_sum   = sum_add;
                n_count = count_inc;
                n_phase = (count_inc >= r_end) ? PH_CRC : PH_DATA;
            end
            PH_CRC: begin
                n_phase = PH_HEADER;
            end
            default: begin
                // hunting; unused codes land here too
                n_phase = PH_HEADER;
                if ((i_rx_byte & HDR_MASK) == HDR_MATCH) begin
                    n_type  = i_rx_byte[2:0];
                    n_sum   = SUM_SEED + i_rx_byte;
                    n_count = LEN_W'(1);
                    n_phase = PH_LENGTH;
                end
            end
        endcase
    end

    // per-byte outputs
    always_comb begin
        pv     = 1'b0;
        done   = 1'b0;
        status = ST_INTEGRITY_OK;
        case (r_phase)
            PH_LENGTH: begin
                if (size_bad) begin
                    done   = 1'b1;
                    status = ST_SIZE_MISMATCH;
                end
            end
            PH_DATA: begin
                pv = 1'b1;
            end
            PH_CRC: begin
                done = 1'b1;
                if (i_rx_byte != r_sum)
                    status = ST_BAD_CHECKSUM;
                else if (r_type == TYPE_ADDRESSED)
                    status = ST_ADDRESSED_OK;
                else if (r_type == TYPE_INTEGRITY)
                    status = ST_INTEGRITY_OK;
                else
                    status = ST_UNKNOWN_OK;
            end
            default: begin
                pv = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_result.payload_valid = pv;
        o_result.payload_byte  = pv ? i_rx_byte : '0;
        o_result.frame_done    = done;
        o_result.frame_status  = status;
        o_result.frame_type    = n_type;
        o_result.dest_host     = n_dest[7:4];
        o_result.dest_port     = n_dest[3:0];
        o_result.src_host      = n_src[7:4];
        o_result.src_port      = n_src[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_type  <= '0;
            r_sum   <= SUM_SEED;
            r_count <= '0;
            r_end   <= '0;
            r_dest  <= '0;
            r_src   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_end   <= n_end;
            r_dest  <= n_dest;
            r_src   <= n_src;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lnp_packet_receiver.sv =====
// Top level of the link-packet receiver: input handshake, parse core, result register.
// Depends on lnp_pkg and lnp_parse_core.
//
// Usage:
//   Input channel: i_valid / o_stall with i_rx_byte and i_burst_len. A word is
//   taken at a rising edge where i_valid is high and o_stall is low. Every
//   accepted byte yields exactly one result word.
//   Output channel: o_valid / i_stall with the result fields. A result word is
//   taken at a rising edge where o_valid is high and i_stall is low.
//   The result word for a byte is registered when taken and shows in the next cycle.
//   Throughput: one byte per cycle while o_stall is low. The parse state
//   machine updates in the same cycle the byte is taken, so bytes may follow
//   back to back; the result register is the only stage.
//   Stall: while the result register holds a word the receiver has not taken
//   and i_stall is high, o_stall is raised and no new byte is taken; the held
//   word stays unchanged. When the result is taken, a new byte may be taken
//   in that same cycle.
//   Reset (i_rst_n low, synchronous): the parser returns to header hunt with
//   the sum seeded to 0xFF, counters and captured addresses cleared, and the
//   result register empty.
`default_nettype none

module lnp_packet_receiver
    import lnp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic [LEN_W-1:0]  i_burst_len,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_payload_valid,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic                   o_frame_done,
    output logic [2:0]             o_frame_status,
    output logic [2:0]             o_frame_type,
    output logic [3:0]             o_dest_host,
    output logic [3:0]             o_dest_port,
    output logic [3:0]             o_src_host,
    output logic [3:0]             o_src_port
);

    t_result r_out;
    logic    r_valid;
    t_result result;
    logic    accept;

    // hold off the sender only while a result word sits untaken
    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    lnp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_rx_byte   (i_rx_byte),
        .i_burst_len (i_burst_len),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_valid;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_frame_done    = r_out.frame_done;
    assign o_frame_status  = r_out.frame_status;
    assign o_frame_type    = r_out.frame_type;
    assign o_dest_host     = r_out.dest_host;
    assign o_dest_port     = r_out.dest_port;
    assign o_src_host      = r_out.src_host;
    assign o_src_port      = r_out.src_port;

endmodule

`default_nettype wire
